@@ hdl/dqs_pkg.sv @@
// Shared constants for the double-ended queue with linear search.
// Holds capacity, derived widths, request codes and status codes; no dependencies.
`default_nettype none

package dqs_pkg;

	// Ring size and derived widths
	localparam int unsigned CAPACITY = 16;
	localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

	// Fixed widths of the request and result fields
	localparam int unsigned FUNC_W   = 2;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned POS_W    = 5;
	localparam int unsigned OCC_W    = 5;

	// Request codes
	typedef enum logic [FUNC_W-1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_REAR  = 2'd1,
		OP_POP_REAR   = 2'd2,
		OP_SEARCH     = 2'd3
	} op_t;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

@@ hdl/deque_with_search_core.sv @@
// Bounded double-ended queue of signed 32-bit values with a front-to-rear search.
// Depends on dqs_pkg for capacity, widths and codes.
//
// A request is taken when start is high and busy is low. Push front, push rear
// and pop rear need no busy state: the result strobe done rises the cycle
// after the request and busy stays low, so a new request may follow at once.
// A search reads one ring entry per cycle through the store's single read port
// and compares it in the next cycle, walking from the front entry to the rear,
// until it finds a match or has compared the rear entry; busy is high meanwhile.
// Each result is presented for exactly one cycle with done high and must be
// taken then: the block has no way to hold a result back. An empty search or
// pop and a push to a full store report at once with their status.
`default_nettype none

module deque_with_search_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [dqs_pkg::FUNC_W-1:0]         func,
	input  wire logic signed [dqs_pkg::VALUE_W-1:0] value,
	output logic                                    done,
	output logic [dqs_pkg::STATUS_W-1:0]            status,
	output logic                                    found,
	output logic [dqs_pkg::POS_W-1:0]               position,
	output logic [dqs_pkg::OCC_W-1:0]               occupancy
);

	typedef enum logic {
		S_IDLE,
		S_SRCH
	} state_t;

	state_t                                state_q;
	logic [dqs_pkg::IDX_W-1:0]             front_q;
	logic [dqs_pkg::CNT_W-1:0]             count_q;
	logic [dqs_pkg::VALUE_W-1:0]           key_q;
	logic [dqs_pkg::IDX_W-1:0]             rd_off_q;
	logic [dqs_pkg::IDX_W-1:0]             cmp_off_q;
	logic                                  cmp_vld_q;
	logic [dqs_pkg::VALUE_W-1:0]           rdata_q;
	logic                                  done_q;
	logic [dqs_pkg::STATUS_W-1:0]          status_q;
	logic                                  found_q;
	logic [dqs_pkg::POS_W-1:0]             position_q;

	logic [dqs_pkg::VALUE_W-1:0]           mem [dqs_pkg::CAPACITY];

	logic                                  accept;
	dqs_pkg::op_t                          op;
	logic                                  is_full;
	logic                                  is_empty;
	logic [dqs_pkg::IDX_W-1:0]             front_dec;
	logic                                  wr_en;
	logic [dqs_pkg::IDX_W-1:0]             wr_addr;
	logic [dqs_pkg::IDX_W-1:0]             rd_addr;
	logic [dqs_pkg::IDX_W-1:0]             last_off;

	// Map an offset from the front onto a ring slot
	function automatic logic [dqs_pkg::IDX_W-1:0] ring_slot(
		input logic [dqs_pkg::IDX_W-1:0] base,
		input logic [dqs_pkg::IDX_W-1:0] off
	);
		logic [dqs_pkg::IDX_W:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= (dqs_pkg::IDX_W+1)'(dqs_pkg::CAPACITY)) begin
			sum = sum - (dqs_pkg::IDX_W+1)'(dqs_pkg::CAPACITY);
		end
		return sum[dqs_pkg::IDX_W-1:0];
	endfunction

	// Decode the request
	assign accept    = start && (state_q == S_IDLE);
	assign op        = dqs_pkg::op_t'(func);
	assign is_full   = (count_q >= dqs_pkg::CNT_W'(dqs_pkg::CAPACITY));
	assign is_empty  = (count_q == '0);
	assign front_dec = (front_q == '0) ? dqs_pkg::IDX_W'(dqs_pkg::CAPACITY - 1)
	                                   : front_q - 1'b1;
	assign last_off  = dqs_pkg::IDX_W'(count_q - 1'b1);

	// Pick the write slot for a push
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = front_dec;
		if (accept && !is_full) begin
			case (op)
				dqs_pkg::OP_PUSH_FRONT: begin
					wr_en   = 1'b1;
					wr_addr = front_dec;
				end
				dqs_pkg::OP_PUSH_REAR: begin
					wr_en   = 1'b1;
					wr_addr = ring_slot(front_q, count_q[dqs_pkg::IDX_W-1:0]);
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	assign rd_addr = ring_slot(front_q, rd_off_q);

	// Element store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= value;
		end
		rdata_q <= mem[rd_addr];
	end

	// Sequencer: queue pointers, search walk and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			front_q    <= '0;
			count_q    <= '0;
			key_q      <= '0;
			rd_off_q   <= '0;
			cmp_off_q  <= '0;
			cmp_vld_q  <= 1'b0;
			done_q     <= 1'b0;
			status_q   <= dqs_pkg::ST_OK;
			found_q    <= 1'b0;
			position_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q   <= dqs_pkg::ST_OK;
						found_q    <= 1'b0;
						position_q <= '0;
						unique case (op)
							dqs_pkg::OP_PUSH_FRONT: begin
								done_q <= 1'b1;
								if (is_full) begin
									status_q <= dqs_pkg::ST_FULL;
								end else begin
									front_q <= front_dec;
									count_q <= count_q + 1'b1;
								end
							end
							dqs_pkg::OP_PUSH_REAR: begin
								done_q <= 1'b1;
								if (is_full) begin
									status_q <= dqs_pkg::ST_FULL;
								end else begin
									count_q <= count_q + 1'b1;
								end
							end
							dqs_pkg::OP_POP_REAR: begin
								done_q <= 1'b1;
								if (is_empty) begin
									status_q <= dqs_pkg::ST_EMPTY;
								end else begin
									count_q <= count_q - 1'b1;
								end
							end
							dqs_pkg::OP_SEARCH: begin
								if (is_empty) begin
									done_q   <= 1'b1;
									status_q <= dqs_pkg::ST_EMPTY;
								end else begin
									// Start the walk at the front entry
									key_q     <= value;
									rd_off_q  <= '0;
									cmp_vld_q <= 1'b0;
									state_q   <= S_SRCH;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_SRCH: begin
					// Advance the read offset and track the entry now in rdata_q
					rd_off_q  <= rd_off_q + 1'b1;
					cmp_off_q <= rd_off_q;
					cmp_vld_q <= 1'b1;
					if (cmp_vld_q) begin
						if (rdata_q == key_q) begin
							found_q    <= 1'b1;
							position_q <= dqs_pkg::POS_W'(cmp_off_q) + 1'b1;
							done_q     <= 1'b1;
							state_q    <= S_IDLE;
						end else if (cmp_off_q == last_off) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Drive the result ports
	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign status    = status_q;
	assign found     = found_q;
	assign position  = position_q;
	assign occupancy = dqs_pkg::OCC_W'(count_q);

endmodule

`default_nettype wire
